>>> src/sdr_pkg.sv
package sdr_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int SECT_AW      = $clog2(SECTOR_BYTES);
    localparam int SPOS_W       = SECT_AW + 1;
    localparam int PADDR_W      = 3;
    localparam int CMD_BYTES    = 6;
    localparam int ECHO_BYTES   = 4;

    localparam logic [7:0] CMD_GO_IDLE    = 8'h40;
    localparam logic [7:0] CMD_SEND_IF    = 8'h48;
    localparam logic [7:0] CMD_READ_BLOCK = 8'h51;
    localparam logic [7:0] CMD_APP        = 8'h77;
    localparam logic [7:0] ACMD_OP_COND   = 8'h69;

    localparam logic [7:0] R1_READY   = 8'h00;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_ERROR   = 8'h40;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] CRC_BYTE   = 8'h00;

    localparam logic [2:0] CMD_LAST   = 3'(CMD_BYTES - 1);
    localparam logic [2:0] ECHO_END   = 3'(ECHO_BYTES + 1);

    localparam logic REG_ENABLED = 1'b0;
    localparam logic REG_POLLS   = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FILL  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CARD_SD    = 3'b001,
        CARD_INIT  = 3'b010,
        CARD_READY = 3'b100
    } card_t;

    typedef enum logic [8:0] {
        XF_IDLE  = 9'b000000001,
        XF_CMD   = 9'b000000010,
        XF_R1    = 9'b000000100,
        XF_R7    = 9'b000001000,
        XF_R1D   = 9'b000010000,
        XF_TOKEN = 9'b000100000,
        XF_DATA  = 9'b001000000,
        XF_CRC1  = 9'b010000000,
        XF_CRC2  = 9'b100000000
    } xfer_t;

    typedef struct packed {
        logic       enabled;
        logic [3:0] ready_after_polls;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic [8:0] fill_index;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        block_request;
        logic [31:0] block_number;
    } rsp_t;

endpackage

>>> src/sdr_if.sv
interface sdr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [8:0] fill_index;

    modport source (output valid, output op, output data_byte, output fill_index,
                    input ready);
    modport sink (input valid, input op, input data_byte, input fill_index,
                  output ready);
endinterface

interface sdr_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        block_request;
    logic [31:0] block_number;

    modport source (output valid, output read_data, output block_request,
                    output block_number, input ready);
    modport sink (input valid, input read_data, input block_request,
                  input block_number, output ready);
endinterface

>>> src/sdr_regs.sv
module sdr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sdr_pkg::cfg_t               cfg
);
    import sdr_pkg::*;

    logic       enabled_reg;
    logic [3:0] polls_reg;
    logic       sel;
    logic       wr;

    assign sel    = paddr[PADDR_W-1];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            polls_reg   <= 4'd6;
        end
        else if (wr)
        begin
            case (sel)
                REG_ENABLED: enabled_reg <= pwdata[0];
                REG_POLLS:   polls_reg   <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_ENABLED: prdata = {31'd0, enabled_reg};
            REG_POLLS:   prdata = {28'd0, polls_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.enabled           = enabled_reg;
    assign cfg.ready_after_polls = polls_reg;

endmodule

>>> src/sdr_engine.sv
module sdr_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  sdr_pkg::req_t item,
    input  sdr_pkg::cfg_t cfg,
    output sdr_pkg::rsp_t result
);
    import sdr_pkg::*;

    card_t             card_reg, card_next;
    xfer_t             xf_reg, xf_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [7:0]        cmd_reg [CMD_BYTES];
    logic [7:0]        cmd_next [CMD_BYTES];
    logic [7:0]        echo_reg [ECHO_BYTES];
    logic [7:0]        echo_next [ECHO_BYTES];
    logic [2:0]        epos_reg, epos_next;
    logic [7:0]        staged_reg, staged_next;
    logic              smem_reg, smem_next;
    logic              app_reg, app_next;
    logic [3:0]        poll_reg, poll_next;
    logic [SPOS_W-1:0] spos_reg, spos_next;

    logic [7:0]        sector_mem [SECTOR_BYTES];
    logic [7:0]        mem_q_reg;
    logic              mem_we;
    logic              mem_re;

    logic [7:0]        staged_cur;
    logic [3:0]        poll_inc;
    logic [SPOS_W-1:0] spos_inc;
    logic [1:0]        echo_idx;
    logic [7:0]        opcode;

    // staged byte comes from the sector read register during data transfer
    assign staged_cur = smem_reg ? mem_q_reg : staged_reg;
    assign poll_inc   = poll_reg + 4'd1;
    assign spos_inc   = spos_reg + SPOS_W'(1);
    assign echo_idx   = 2'(epos_reg - 3'd1);
    assign opcode     = cmd_reg[0];

    always_comb
    begin
        card_next   = card_reg;
        xf_next     = xf_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        echo_next   = echo_reg;
        epos_next   = epos_reg;
        staged_next = staged_reg;
        smem_next   = smem_reg;
        app_next    = app_reg;
        poll_next   = poll_reg;
        spos_next   = spos_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        result.read_data     = BYTE_IDLE;
        result.block_request = 1'b0;
        result.block_number  = '0;

        case (item.op)
            OP_FILL:
            begin
                mem_we = 1'b1;
            end
            OP_READ:
            begin
                if (cfg.enabled)
                begin
                    result.read_data = staged_cur;
                    smem_next        = 1'b0;
                    case (xf_reg)
                        XF_R1:
                        begin
                            staged_next = BYTE_IDLE;
                            xf_next     = XF_IDLE;
                        end
                        XF_R7:
                        begin
                            if (epos_reg >= ECHO_END)
                            begin
                                staged_next = BYTE_IDLE;
                                xf_next     = XF_IDLE;
                                epos_next   = 3'd0;
                            end
                            else
                            begin
                                staged_next = echo_reg[echo_idx];
                                epos_next   = epos_reg + 3'd1;
                            end
                        end
                        XF_R1D:
                        begin
                            staged_next = BYTE_IDLE;
                            xf_next     = XF_TOKEN;
                        end
                        XF_TOKEN:
                        begin
                            staged_next = TOKEN_DATA;
                            xf_next     = XF_DATA;
                            spos_next   = '0;
                        end
                        XF_DATA:
                        begin
                            mem_re    = 1'b1;
                            smem_next = 1'b1;
                            spos_next = spos_inc;
                            if (spos_inc >= SPOS_W'(SECTOR_BYTES))
                                xf_next = XF_CRC1;
                        end
                        XF_CRC1:
                        begin
                            staged_next = CRC_BYTE;
                            xf_next     = XF_CRC2;
                        end
                        XF_CRC2:
                        begin
                            staged_next = CRC_BYTE;
                            xf_next     = XF_IDLE;
                        end
                        default:
                        begin
                            staged_next = BYTE_IDLE;
                        end
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (cfg.enabled && (xf_reg == XF_CMD ||
                                    (xf_reg == XF_IDLE && !item.data_byte[7])))
                begin
                    xf_next           = XF_CMD;
                    cmd_next[cnt_reg] = item.data_byte;
                    cnt_next          = cnt_reg + 3'd1;
                    if (cnt_reg == CMD_LAST)
                    begin
                        cnt_next = 3'd0;
                        if (app_reg)
                        begin
                            app_next = 1'b0;
                            if (card_reg == CARD_INIT)
                            begin
                                if (opcode == ACMD_OP_COND)
                                begin
                                    poll_next = poll_inc;
                                    xf_next   = XF_R1;
                                    smem_next = 1'b0;
                                    if (poll_inc == cfg.ready_after_polls)
                                    begin
                                        card_next   = CARD_READY;
                                        staged_next = R1_READY;
                                    end
                                    else
                                        staged_next = R1_IDLE;
                                end
                            end
                            else
                            begin
                                xf_next     = XF_R1;
                                staged_next = R1_ERROR;
                                smem_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            case (card_reg)
                                CARD_SD:
                                begin
                                    if (opcode == CMD_GO_IDLE)
                                        card_next = CARD_INIT;
                                    xf_next     = XF_R1;
                                    staged_next = R1_IDLE;
                                    smem_next   = 1'b0;
                                end
                                CARD_INIT:
                                begin
                                    if (opcode == CMD_SEND_IF)
                                    begin
                                        xf_next     = XF_R7;
                                        staged_next = R1_IDLE;
                                        smem_next   = 1'b0;
                                        epos_next   = 3'd1;
                                        for (int i = 0; i < ECHO_BYTES; i++)
                                            echo_next[i] = cmd_reg[i+1];
                                    end
                                    else if (opcode == CMD_APP)
                                    begin
                                        app_next    = 1'b1;
                                        xf_next     = XF_R1;
                                        staged_next = R1_IDLE;
                                        smem_next   = 1'b0;
                                    end
                                end
                                CARD_READY:
                                begin
                                    smem_next = 1'b0;
                                    if (opcode == CMD_READ_BLOCK)
                                    begin
                                        xf_next     = XF_R1D;
                                        staged_next = R1_READY;
                                        result.block_request = 1'b1;
                                        result.block_number  = {cmd_reg[1], cmd_reg[2],
                                                                cmd_reg[3], cmd_reg[4]};
                                    end
                                    else
                                    begin
                                        xf_next     = XF_R1;
                                        staged_next = R1_ERROR;
                                    end
                                end
                                default:
                                begin
                                    xf_next     = XF_R1;
                                    staged_next = R1_IDLE;
                                    smem_next   = 1'b0;
                                end
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_reg   <= CARD_SD;
            xf_reg     <= XF_IDLE;
            cnt_reg    <= 3'd0;
            epos_reg   <= 3'd0;
            staged_reg <= BYTE_IDLE;
            smem_reg   <= 1'b0;
            app_reg    <= 1'b0;
            poll_reg   <= 4'd0;
            spos_reg   <= '0;
        end
        else if (go)
        begin
            card_reg   <= card_next;
            xf_reg     <= xf_next;
            cnt_reg    <= cnt_next;
            epos_reg   <= epos_next;
            staged_reg <= staged_next;
            smem_reg   <= smem_next;
            app_reg    <= app_next;
            poll_reg   <= poll_next;
            spos_reg   <= spos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            cmd_reg  <= cmd_next;
            echo_reg <= echo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && mem_we)
            sector_mem[item.fill_index] <= item.data_byte;
        if (go && mem_re)
            mem_q_reg <= sector_mem[spos_reg[SECT_AW-1:0]];
    end

endmodule

>>> src/sd_card_spi_mode_responder.sv
// SPI-mode SD card responder, card side.
// req channel: one request per host SPI byte (op write/read) or per sector
//   store fill (op fill, data_byte at fill_index). Each request yields
//   exactly one item on rsp: read_data (staged byte on an enabled host read, 0xFF
//   otherwise), block_request/block_number raised by a completed CMD17.
// Config: APB registers enabled (0x0) and ready_after_polls (0x4); write
//   only while no request is in flight.
// Path: a request passes the input register, then the response register.
//   Throughput: one request per cycle unless rsp stalls; the state update
//   and the sector store access of one request happen in the same cycle,
//   and the sector read data register is consumed by the next read.
// Reset: card in SD mode, transfer idle, staged byte 0xFF, card disabled,
//   poll target 6. The sector store is not cleared; the user must fill
//   sectors by fill requests before they are read; the block does not enforce it.
// Stall: the response register holds while rsp.ready is low; one more
//   request is taken into the input register, then req.ready drops until
//   the response is taken.
module sd_card_spi_mode_responder (
    input  logic                        clk,
    input  logic                        rst_n,
    sdr_req_if.sink                     req,
    sdr_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sdr_pkg::*;

    cfg_t cfg;
    req_t in_item_reg;
    logic in_valid_reg;
    rsp_t result;
    rsp_t out_item_reg;
    logic out_valid_reg;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    sdr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdr_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.op         <= op_t'(req.op);
            in_item_reg.data_byte  <= req.data_byte;
            in_item_reg.fill_index <= req.fill_index;
        end
        if (advance)
            out_item_reg <= result;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_item_reg.read_data;
    assign rsp.block_request = out_item_reg.block_request;
    assign rsp.block_number  = out_item_reg.block_number;

endmodule

>>> src/sdr_checker.sv
module sdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic        block_request,
    input logic [31:0] block_number
);

    // a stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) &&
        $stable(block_request) && $stable(block_number))
        else $error("response changed while stalled");

    // an accepted request is followed by a valid response
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("response missing after request");

    // an empty response register never blocks requests
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled with empty response register");

    // block number is zero unless a block request is raised
    a_block_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !block_request |-> block_number == 32'd0)
        else $error("block number without block request");

endmodule

bind sd_card_spi_mode_responder sdr_checker u_sdr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .read_data     (rsp.read_data),
    .block_request (rsp.block_request),
    .block_number  (rsp.block_number)
);
